// ----- src/heq_pkg.sv -----
// ----------------------------------------------------------------------------
// heq_pkg
// Types and constants shared by the histogram equalization map block.
// ----------------------------------------------------------------------------
package heq_pkg;

  localparam int BINS_DEF = 256;
  localparam int GREY_W   = 8;
  localparam int COUNT_W  = 16;

  localparam logic [GREY_W-1:0]  GREY_MAX  = 8'hff;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hffff;

  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [GREY_W-1:0] grey;
    logic              last;
  } heq_in_t;

  typedef struct packed {
    logic [GREY_W-1:0] mapped;
    logic              ready_res;
    logic              overflow;
  } heq_out_t;

endpackage

// ----- src/heq_div.sv -----
// ----------------------------------------------------------------------------
// heq_div
// Iterative restoring divider: one quotient bit per cycle; done strobes
// in the cycle in which the final quotient bit is on quo.
// ----------------------------------------------------------------------------
module heq_div #(
  parameter int QW = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              go,
  input  logic [heq_pkg::COUNT_W+QW-1:0]    num,
  input  logic [heq_pkg::COUNT_W-1:0]       den,
  output logic                              done,
  output logic [QW-1:0]                     quo
);
  import heq_pkg::*;

  localparam int NW = COUNT_W + QW;
  localparam int SW = (QW > 1) ? $clog2(QW) : 1;

  logic [NW-1:0]      rem_r, rem_nxt;
  logic [COUNT_W-1:0] den_r;
  logic [QW-1:0]      q_r, q_nxt;
  logic [SW-1:0]      step_r;
  logic               run_r;
  logic               done_r;
  logic [NW-1:0]      dsh;
  logic               fits;

  assign dsh  = NW'(den_r) << step_r;
  assign fits = rem_r >= dsh;

  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    if (fits) begin
      rem_nxt = rem_r - dsh;
      q_nxt   = q_r | (QW'(1) << step_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r  <= 1'b1;
        step_r <= SW'(QW - 1);
      end else if (run_r) begin
        step_r <= step_r - SW'(1);
        if (step_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= num;
      den_r <= den;
      q_r   <= '0;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ----- src/histogram_equalization_map_top.sv -----
// ----------------------------------------------------------------------------
// histogram_equalization_map_top
// Grey-level histogram with in-place equalization map.
//
// Input: an item transfers when start is high and busy is low. Kinds:
// start (clear for a new image), pixel (count into its bin) and lookup.
// Output: a lookup gives one result on out_data, marked by out_valid for
// exactly one cycle, in the cycle after its transfer. The receiver cannot stall.
// Pixels and lookups transfer one per cycle while busy is low; bin
// updates are read-modify-write on a single memory with forwarding
// between back-to-back pixels. The last pixel starts the map build,
// busy through a flush state and per bin the states RD, ACC, MUL and
// DIV, the serial divider giving one quotient bit per cycle. A start item,
// and reset, run a clearing pass over the memory, busy, one entry per cycle.
// ----------------------------------------------------------------------------
module histogram_equalization_map_top #(
  parameter int BINS = heq_pkg::BINS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  heq_pkg::heq_in_t  in_item,
  output logic              out_valid,
  output heq_pkg::heq_out_t out_data
);
  import heq_pkg::*;

  localparam int BW = $clog2(BINS);
  localparam int NW = COUNT_W + BW;
  localparam logic [NW-1:0] SCALE = NW'(BINS - 1);
  localparam logic [BW-1:0] LAST_BIN = BW'(BINS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_FLUSH = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_ACC   = 3'd4;
  localparam logic [2:0] ST_MUL   = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;

  logic [COUNT_W-1:0] mem [BINS];
  logic [COUNT_W-1:0] rd_data_r;

  logic [2:0]         state_r, state_nxt;
  logic [BW-1:0]      k_r, k_nxt;
  logic [COUNT_W-1:0] cum_r, cum_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic               built_r, built_nxt;
  logic               dropped_r, dropped_nxt;

  logic               px_vld_r;
  logic [BW-1:0]      px_addr_r;
  logic               fw_vld_r;
  logic [BW-1:0]      fw_addr_r;
  logic [COUNT_W-1:0] fw_data_r;

  logic               lk_vld_r;
  logic               lk_built_r;
  logic               lk_ovf_r;

  logic               acc;
  logic               acc_start, acc_pixel, acc_lookup;
  logic               px_count;
  logic [BW-1:0]      bin;
  logic [COUNT_W-1:0] px_cur, px_new;

  logic               we;
  logic [BW-1:0]      wa;
  logic [COUNT_W-1:0] wd;
  logic [BW-1:0]      ra;

  logic               div_go;
  logic               div_done;
  logic [BW-1:0]      div_q;
  logic [COUNT_W-1:0] map_val;

  assign busy       = state_r != ST_IDLE;
  assign acc        = start && !busy;
  assign acc_start  = acc && in_item.kind == KIND_START;
  assign acc_pixel  = acc && in_item.kind == KIND_PIXEL && !built_r;
  assign acc_lookup = acc && in_item.kind == KIND_LOOKUP;
  assign px_count   = acc_pixel && total_r != COUNT_MAX;

  assign bin = (int'(in_item.grey) >= BINS) ? LAST_BIN : BW'(in_item.grey);

  assign px_cur = (fw_vld_r && fw_addr_r == px_addr_r) ? fw_data_r : rd_data_r;
  assign px_new = px_cur + COUNT_W'(1);

  assign map_val = (total_r == '0) ? '0 :
                   (COUNT_W'(div_q) > COUNT_W'(GREY_MAX)) ? COUNT_W'(GREY_MAX) :
                   COUNT_W'(div_q);

  assign div_go = state_r == ST_MUL;

  heq_div #(
    .QW (BW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num   (NW'(cum_r) * SCALE),
    .den   (total_r),
    .done  (div_done),
    .quo   (div_q)
  );

  always_comb begin
    we = 1'b0;
    wa = k_r;
    wd = '0;
    ra = busy ? k_r : bin;
    if (state_r == ST_CLEAR) begin
      we = 1'b1;
    end else if (state_r == ST_DIV && div_done) begin
      we = 1'b1;
      wd = map_val;
    end else if (px_vld_r) begin
      we = 1'b1;
      wa = px_addr_r;
      wd = px_new;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    cum_nxt     = cum_r;
    total_nxt   = total_r;
    built_nxt   = built_r;
    dropped_nxt = dropped_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc_start) begin
          state_nxt   = ST_CLEAR;
          k_nxt       = '0;
          total_nxt   = '0;
          built_nxt   = 1'b0;
          dropped_nxt = 1'b0;
        end else if (acc_pixel) begin
          if (px_count) begin
            total_nxt = total_r + COUNT_W'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_item.last) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_CLEAR: begin
        k_nxt = k_r + BW'(1);
        if (k_r == LAST_BIN) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_RD;
        k_nxt     = '0;
        cum_nxt   = '0;
      end
      ST_RD: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cum_nxt   = cum_r + rd_data_r;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          k_nxt = k_r + BW'(1);
          if (k_r == LAST_BIN) begin
            state_nxt = ST_IDLE;
            built_nxt = 1'b1;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      k_r        <= '0;
      total_r    <= '0;
      built_r    <= 1'b0;
      dropped_r  <= 1'b0;
      px_vld_r   <= 1'b0;
      fw_vld_r   <= 1'b0;
      lk_vld_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      k_r        <= k_nxt;
      total_r    <= total_nxt;
      built_r    <= built_nxt;
      dropped_r  <= dropped_nxt;
      px_vld_r   <= px_count;
      fw_vld_r   <= px_vld_r;
      lk_vld_r   <= acc_lookup;
    end
  end

  always_ff @(posedge clk) begin
    cum_r      <= cum_nxt;
    px_addr_r  <= bin;
    fw_addr_r  <= px_addr_r;
    fw_data_r  <= px_new;
    lk_built_r <= built_r;
    lk_ovf_r   <= dropped_r;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[ra];
  end

  assign out_valid          = lk_vld_r;
  assign out_data.mapped    = lk_built_r ? rd_data_r[GREY_W-1:0] : '0;
  assign out_data.ready_res = lk_built_r;
  assign out_data.overflow  = lk_ovf_r;

endmodule
